[hdl/artl_pkg.sv]
// Shared types, constants and codes of the address range table lookup unit.
package artl_pkg;

  // Table size and the widths derived from it.
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // The match reduction is a registered tree of sixteen-input nodes.
  localparam int unsigned TREE_FANIN = 16;
  localparam int unsigned TREE_LVLS = ($clog2(CAPACITY) + 3) / 4;
  localparam int unsigned TREE_LEAVES = 1 << (4 * TREE_LVLS);
  localparam int unsigned TREE_CW = $clog2(TREE_LVLS) + 1;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] range_start;
    logic [31:0] range_length;
    logic [31:0] entry_tag;
    logic [31:0] target_address;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic        found;
    logic [31:0] hit_tag;
    logic [31:0] hit_start;
    logic [8:0]  table_count;
    logic        load_dropped;
  } out_item_t;

  // One table entry as held in a cell.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] tag;
  } entry_t;

  // A cell's lookup contribution: the entry if it is the selected one, else zero.
  typedef struct packed {
    logic   sel;
    entry_t entry;
  } hit_t;

  // Per-cycle controls broadcast to every cell.
  typedef struct packed {
    logic shift_en;
    logic cmp_en;
    logic sel_en;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_SEL,
    ST_TREE,
    ST_CHECK
  } state_e;

endpackage

[hdl/artl_cell.sv]
// One cell of the sorted table: holds an entry, inserts in order and flags lookup matches.
module artl_cell (
  input  logic               clk_i,
  input  artl_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,
  input  logic [31:0]        key_i,
  input  artl_pkg::entry_t   new_i,
  input  artl_pkg::entry_t   prev_i,
  input  logic               prev_ge_i,
  input  logic               next_le_i,
  output artl_pkg::entry_t   entry_o,
  output logic               ge_o,
  output logic               le_o,
  output artl_pkg::hit_t     hit_o
);
  import artl_pkg::*;

  entry_t entry_q;
  logic   le_q;
  hit_t   hit_q;
  logic   le_w;
  logic   sel_w;

  // An occupied cell whose start is not above the key sits before the key.
  assign le_w = occ_i && (entry_q.start <= key_i);
  assign ge_o = !le_w;

  // This cell is the last one not above the target.
  assign sel_w = le_q && !next_le_i;

  // Insertion shifts the upper part of the row by one cell; lookups compare, then select.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en && !le_w) begin
      entry_q <= prev_ge_i ? prev_i : new_i;
    end
    if (ctrl_i.cmp_en) begin
      le_q <= le_w;
    end
    if (ctrl_i.sel_en) begin
      hit_q.sel   <= sel_w;
      hit_q.entry <= sel_w ? entry_q : '0;
    end
  end

  assign entry_o = entry_q;
  assign le_o    = le_q;
  assign hit_o   = hit_q;

endmodule

[hdl/artl_tree.sv]
// Registered sixteen-input OR tree that gathers the single selected cell's entry.
module artl_tree (
  input  logic           clk_i,
  input  artl_pkg::hit_t hit_i [artl_pkg::CAPACITY],
  output artl_pkg::hit_t root_o
);
  import artl_pkg::*;

  hit_t src_w  [TREE_LVLS + 1][TREE_LEAVES];
  hit_t node_q [1:TREE_LVLS][TREE_LEAVES];

  // Level zero holds the cell outputs, padded with zeros; higher levels are registers.
  always_comb begin
    for (int j = 0; j < TREE_LEAVES; j++) begin
      src_w[0][j] = (j < CAPACITY) ? hit_i[j] : '0;
    end
    for (int l = 1; l <= TREE_LVLS; l++) begin
      for (int j = 0; j < TREE_LEAVES; j++) begin
        src_w[l][j] = node_q[l][j];
      end
    end
  end

  // Each node ORs sixteen children; at most one child anywhere is nonzero.
  always_ff @(posedge clk_i) begin
    hit_t acc;
    for (int l = 1; l <= TREE_LVLS; l++) begin
      for (int j = 0; j < TREE_LEAVES; j++) begin
        acc = '0;
        if (j < (TREE_LEAVES >> (4 * l))) begin
          for (int k = 0; k < TREE_FANIN; k++) begin
            acc = acc | src_w[l - 1][TREE_FANIN * j + k];
          end
        end
        node_q[l][j] <= acc;
      end
    end
  end

  assign root_o = node_q[TREE_LVLS][0];

endmodule

[hdl/address_range_table_lookup_unit.sv]
// Top level of the address range table lookup unit: cell row, match tree and sequencer.
//
// The table holds up to CAPACITY ranges in a row of cells kept sorted by start
// address; each cell holds one entry and compares it against the broadcast key.
// One transaction is processed at a time. A clear or load passes the RUN and CHECK
// states before the next acceptance; the insertion shifts the upper part of the
// row in RUN. A lookup passes the RUN, SEL, TREE and CHECK states; TREE waits for
// the registered sixteen-input tree, TREE_LVLS = ceil(log2(CAPACITY) / 4) levels
// deep, that collects the matching cell. A finished result waits in an output
// register, and the next transaction may be accepted meanwhile. Entries become
// visible to lookups as soon as the load's result is produced.
module address_range_table_lookup_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  artl_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output artl_pkg::out_item_t out_data_o
);
  import artl_pkg::*;

  state_e            state_q, state_d;
  in_item_t          req_q;
  logic [CNT_W-1:0]  count_q;
  logic              dropped_q;
  logic [TREE_CW-1:0] tree_cnt_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              in_take_w;
  logic              out_load_w;
  logic              full_w;
  cell_ctrl_t        ctrl_w;
  logic [31:0]       key_w;
  entry_t            new_w;
  logic [31:0]       diff_w;
  logic              found_w;
  hit_t              root_w;

  entry_t            entry_w [CAPACITY];
  logic              ge_w    [CAPACITY];
  logic              le_w    [CAPACITY];
  logic              occ_w   [CAPACITY];
  hit_t              hit_w   [CAPACITY];

  assign in_take_w = in_valid_i && !in_stall_o;
  assign full_w    = (count_q == CNT_W'(CAPACITY));

  // Key and new entry broadcast to every cell.
  assign key_w = (req_q.func == FUNC_LOAD) ? req_q.range_start : req_q.target_address;
  assign new_w = '{start: req_q.range_start, length: req_q.range_length,
                   tag: req_q.entry_tag};

  // Row of cells; each hands its entry and compare result to its upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ_w[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      artl_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl_w),
        .occ_i     (occ_w[i]),
        .key_i     (key_w),
        .new_i     (new_w),
        .prev_i    (new_w),
        .prev_ge_i (1'b0),
        .next_le_i (le_w[i + 1]),
        .entry_o   (entry_w[i]),
        .ge_o      (ge_w[i]),
        .le_o      (le_w[i]),
        .hit_o     (hit_w[i])
      );
    end else if (i == CAPACITY - 1) begin : g_last
      artl_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl_w),
        .occ_i     (occ_w[i]),
        .key_i     (key_w),
        .new_i     (new_w),
        .prev_i    (entry_w[i - 1]),
        .prev_ge_i (ge_w[i - 1]),
        .next_le_i (1'b0),
        .entry_o   (entry_w[i]),
        .ge_o      (ge_w[i]),
        .le_o      (le_w[i]),
        .hit_o     (hit_w[i])
      );
    end else begin : g_mid
      artl_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl_w),
        .occ_i     (occ_w[i]),
        .key_i     (key_w),
        .new_i     (new_w),
        .prev_i    (entry_w[i - 1]),
        .prev_ge_i (ge_w[i - 1]),
        .next_le_i (le_w[i + 1]),
        .entry_o   (entry_w[i]),
        .ge_o      (ge_w[i]),
        .le_o      (le_w[i]),
        .hit_o     (hit_w[i])
      );
    end
  end

  // Reduction of the selected cell's entry.
  artl_tree u_tree (
    .clk_i  (clk_i),
    .hit_i  (hit_w),
    .root_o (root_w)
  );

  // Final range check on the selected entry.
  assign diff_w  = req_q.target_address - root_w.entry.start;
  assign found_w = (req_q.func == FUNC_LOOKUP) && root_w.sel &&
                   (diff_w < root_w.entry.length);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take_w) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = (req_q.func == FUNC_LOOKUP) ? ST_SEL : ST_CHECK;
      end
      ST_SEL: begin
        state_d = ST_TREE;
      end
      ST_TREE: begin
        if (tree_cnt_q == TREE_CW'(TREE_LVLS - 1)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (out_load_w) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ctrl_w     = '0;
    in_stall_o = 1'b1;
    out_load_w = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_RUN: begin
        ctrl_w.shift_en = (req_q.func == FUNC_LOAD) && !full_w;
        ctrl_w.cmp_en   = (req_q.func == FUNC_LOOKUP);
      end
      ST_SEL: begin
        ctrl_w.sel_en = 1'b1;
      end
      ST_TREE: begin
        out_load_w = 1'b0;
      end
      ST_CHECK: begin
        out_load_w = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Control registers: state, entry count, dropped flag, tree wait counter, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      tree_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RUN) begin
        dropped_q <= (req_q.func == FUNC_LOAD) && full_w;
        if (req_q.func == FUNC_CLEAR) begin
          count_q <= '0;
        end else if ((req_q.func == FUNC_LOAD) && !full_w) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (state_q == ST_TREE) begin
        tree_cnt_q <= tree_cnt_q + TREE_CW'(1);
      end else begin
        tree_cnt_q <= '0;
      end
      if (out_load_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: accepted transaction and result.
  always_ff @(posedge clk_i) begin
    if (in_take_w) begin
      req_q <= in_data_i;
    end
    if (out_load_w) begin
      out_q.found        <= found_w;
      out_q.hit_tag      <= found_w ? root_w.entry.tag : '0;
      out_q.hit_start    <= found_w ? root_w.entry.start : '0;
      out_q.table_count  <= 9'(count_q);
      out_q.load_dropped <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A new result only appears after the check state.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_CHECK))
    else $error("result produced outside the check state");

  // The tree wait never outruns the number of tree levels.
  a_tree_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TREE) |-> (tree_cnt_q < TREE_CW'(TREE_LVLS)))
    else $error("tree wait counter overran");

  // A full table leaves the count unchanged on a load.
  a_full_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && req_q.func == FUNC_LOAD && full_w) |=> $stable(count_q))
    else $error("load into a full table changed the count");
`endif

endmodule

[sim/range_table_checker.sv]
// Checker for the address range table lookup unit: a shadow table predicts every result.
module range_table_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  artl_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  artl_pkg::out_item_t out_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         hit_count_o,
  output int unsigned         drop_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import artl_pkg::*;

  // Shadow copy of the table, kept sorted by start address.
  logic [31:0] shadow_start [CAPACITY];
  logic [31:0] shadow_length [CAPACITY];
  logic [31:0] shadow_tag [CAPACITY];
  int unsigned shadow_count;

  // Results predicted for accepted items, oldest first.
  out_item_t   table_replies_due [$];
  out_item_t   want;

  // Number of held entries whose start is not above the key.
  function automatic int unsigned entries_at_or_below(logic [31:0] key);
    int unsigned pos;
    pos = 0;
    while (pos < shadow_count && shadow_start[pos] <= key) pos++;
    return pos;
  endfunction

  // Applies one item to the shadow table and returns the result it should produce.
  function automatic out_item_t apply_table_op(in_item_t op);
    out_item_t   res;
    int unsigned pos;
    int          idx;
    logic [31:0] offset;
    res = '0;
    case (op.func)
      FUNC_CLEAR: begin
        shadow_count = 0;
      end
      FUNC_LOAD: begin
        if (shadow_count >= CAPACITY) begin
          res.load_dropped = 1'b1;
        end else begin
          // A new entry goes after every entry whose start is not above its own.
          pos = entries_at_or_below(op.range_start);
          for (idx = int'(shadow_count); idx > int'(pos); idx--) begin
            shadow_start[idx] = shadow_start[idx - 1];
            shadow_length[idx] = shadow_length[idx - 1];
            shadow_tag[idx] = shadow_tag[idx - 1];
          end
          shadow_start[pos] = op.range_start;
          shadow_length[pos] = op.range_length;
          shadow_tag[pos] = op.entry_tag;
          shadow_count++;
        end
      end
      FUNC_LOOKUP: begin
        // The candidate is the last entry whose start is not above the target.
        pos = entries_at_or_below(op.target_address);
        if (pos > 0) begin
          offset = op.target_address - shadow_start[pos - 1];
          if (offset < shadow_length[pos - 1]) begin
            res.found = 1'b1;
            res.hit_tag = shadow_tag[pos - 1];
            res.hit_start = shadow_start[pos - 1];
          end
        end
      end
      default: begin
      end
    endcase
    res.table_count = 9'(shadow_count);
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input logic [31:0] want_v, got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %h, actual %h", name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  // Watch both channels; predict on input transactions, compare on result transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      table_replies_due.delete();
      fail_count_o = 0;
      hit_count_o = 0;
      drop_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        table_replies_due.push_back(apply_table_op(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (table_replies_due.size() == 0) begin
          $error("Result transaction with no item outstanding: %p", out_data_i);
          fail_count_o++;
        end else begin
          want = table_replies_due.pop_front();
          check_field("found", 32'(want.found), 32'(out_data_i.found));
          check_field("hit_tag", want.hit_tag, out_data_i.hit_tag);
          check_field("hit_start", want.hit_start, out_data_i.hit_start);
          check_field("table_count", 32'(want.table_count), 32'(out_data_i.table_count));
          check_field("load_dropped", 32'(want.load_dropped), 32'(out_data_i.load_dropped));
          if (want.found) hit_count_o++;
          if (want.load_dropped) drop_count_o++;
        end
      end
    end
    pending_o = table_replies_due.size();
  end

endmodule

[sim/testbench.sv]
// Testbench top for the address range table lookup unit: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import artl_pkg::*;

  // The unused selector value performs no operation.
  localparam logic [1:0] FUNC_NOP = 2'd3;

  localparam int unsigned ITEM_TARGET = 550;
  localparam int unsigned HOLD_AT = 120;
  localparam int unsigned LONG_HOLD = 60;
  localparam int unsigned QUIET_AT = 480;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned hit_count;
  int unsigned drop_count;

  // Receiver and watchdog state, written with nonblocking assignments.
  logic        hold_armed = 1'b0;
  logic        quiet = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned rx_burst = 0;
  int unsigned idle_cycles = 0;

  // Stimulus bookkeeping.
  int unsigned sent_total = 0;
  int unsigned sent_loads = 0;
  int unsigned sent_lookups = 0;
  int unsigned sent_clears = 0;
  int unsigned sent_nops = 0;
  logic [31:0] known_starts [$];
  logic [31:0] region_base = '0;

  address_range_table_lookup_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  range_table_checker table_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .hit_count_o  (hit_count),
    .drop_count_o (drop_count)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: one long hold-off, short random stall bursts, none in the final stretch.
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      out_stall_i <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else if (hold_armed && !hold_done) begin
      out_stall_i <= 1'b1;
      rx_hold <= LONG_HOLD - 1;
      hold_done <= 1'b1;
    end else if (rx_burst != 0) begin
      out_stall_i <= 1'b1;
      rx_burst <= rx_burst - 1;
    end else if (rst_ni && !quiet && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      rx_burst <= $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one item, after an optional idle burst, and waits until it is accepted.
  task automatic send_item(input logic [1:0] func, input logic [31:0] start_v, len_v,
                           tag_v, addr_v);
    in_item_t item;
    item.func = func;
    item.range_start = start_v;
    item.range_length = len_v;
    item.entry_tag = tag_v;
    item.target_address = addr_v;
    if (sent_total < QUIET_AT && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    sent_total++;
    case (func)
      FUNC_CLEAR: sent_clears++;
      FUNC_LOAD: sent_loads++;
      FUNC_LOOKUP: sent_lookups++;
      default: sent_nops++;
    endcase
    hold_armed <= (sent_total >= HOLD_AT);
    quiet <= (sent_total >= QUIET_AT);
  endtask

  // Clears the table and moves the address region that new loads cluster in.
  task automatic send_clear();
    send_item(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
    known_starts.delete();
    region_base = $urandom;
  endtask

  // Loads an entry, mostly clustered so that ranges overlap and starts repeat.
  task automatic send_random_load();
    logic [31:0] start_v;
    logic [31:0] len_v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      start_v = $urandom;
    end else if (r < 35 && known_starts.size() != 0) begin
      start_v = known_starts[$urandom_range(0, known_starts.size() - 1)];
    end else begin
      start_v = region_base + $urandom_range(0, 'h3FFF);
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      len_v = '0;
    end else if (r < 20) begin
      len_v = $urandom;
    end else if (r < 25) begin
      len_v = '1;
    end else begin
      len_v = $urandom_range(1, 'h200);
    end
    known_starts.push_back(start_v);
    send_item(FUNC_LOAD, start_v, len_v, $urandom, $urandom);
  endtask

  // Looks up an address, mostly at or near the start of a loaded entry.
  task automatic send_random_lookup();
    logic [31:0] base;
    logic [31:0] addr_v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (known_starts.size() != 0 && r < 80) begin
      base = known_starts[$urandom_range(0, known_starts.size() - 1)];
      if (r < 10) begin
        addr_v = base - 1;
      end else if (r < 20) begin
        addr_v = base;
      end else begin
        addr_v = base + $urandom_range(0, 'h240);
      end
    end else begin
      addr_v = $urandom;
    end
    send_item(FUNC_LOOKUP, $urandom, $urandom, $urandom, addr_v);
  endtask

  // Reset, directed items, random episodes, drain and verdict.
  initial begin : stimulus
    int unsigned idx;
    int unsigned steps;
    int unsigned r;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lookups into an empty table.
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h0000_0000);
    send_item(FUNC_LOOKUP, '1, '1, '1, 32'hFFFF_FFFF);
    // One range: target below it, last byte inside, first byte past it.
    send_item(FUNC_LOAD, 32'h8000_0000, 32'h0000_0100, 32'h1111_1111, '0);
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h0000_0010);
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h8000_00FF);
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h8000_0100);
    // Equal start: the later load is the one selected, even when it is shorter.
    send_item(FUNC_LOAD, 32'h8000_0000, 32'h0000_0010, 32'h2222_2222, '1);
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h8000_0008);
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h8000_0020);
    // A zero-length entry never matches.
    send_item(FUNC_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '0);
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h0000_0000);
    // Extremes of every field.
    send_item(FUNC_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_LOOKUP, '1, '1, '1, 32'hFFFF_FFFF);
    send_item(FUNC_LOAD, 32'h4000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A, '0);
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h7FFF_FFFF);
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h8000_0000);
    // The unused selector changes nothing.
    send_item(FUNC_NOP, '1, '1, '1, '1);
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h4000_0000);
    // Clear with every field high, then look up again.
    send_item(FUNC_CLEAR, '1, '1, '1, '1);
    send_item(FUNC_LOOKUP, '0, '0, '0, 32'h8000_0000);
    send_item(FUNC_LOAD, 32'h0001_0000, 32'h0000_0040, 32'h3333_3333, '0);
    send_item(FUNC_LOOKUP, '1, '1, '1, 32'h0000_FFFF);

    // Fill the table past capacity so that the last loads are refused.
    send_clear();
    for (idx = 0; idx < CAPACITY + 4; idx++) begin
      if ($urandom_range(0, 9) == 0) send_random_lookup();
      send_random_load();
    end
    repeat (12) send_random_lookup();
    send_clear();

    // Short episodes: a few loads mixed with lookups, plus some noise.
    while (sent_total < ITEM_TARGET) begin
      if ($urandom_range(0, 3) != 0) send_clear();
      steps = $urandom_range(4, 30);
      repeat (steps) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          send_random_load();
        end else if (r < 92) begin
          send_random_lookup();
        end else if (r < 97) begin
          send_item(FUNC_NOP, $urandom, $urandom, $urandom, $urandom);
        end else begin
          send_clear();
        end
      end
    end
    in_valid_i <= 1'b0;

    // Wait for every predicted result, then let the block settle.
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d transactions: %0d loads, %0d lookups, %0d clears, %0d no-ops.",
             sent_total, sent_loads, sent_lookups, sent_clears, sent_nops);
    $display("Lookups that hit: %0d; loads refused on a full table: %0d.",
             hit_count, drop_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
